>>> design/xs1024_pkg.sv
// Package for the xorshift1024* generator: action codes, sizes and the
// mixing and scrambling constants. No dependencies.
package xs1024_pkg;

    localparam int STATE_WORDS = 16;
    localparam int IDX_W       = $clog2(STATE_WORDS);
    localparam int WORD_W      = 64;
    localparam int ACTION_W    = 2;

    localparam logic [ACTION_W-1:0] ACT_GENERATE     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_WORD    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SET_POSITION = 2'd2;

    localparam logic [WORD_W-1:0] MIX_MULT = 64'd1181783497276652981;
    localparam int SHIFT_A = 31;
    localparam int SHIFT_B = 11;
    localparam int SHIFT_C = 30;

    // Result queue depth; covers the pipeline: one item per cycle while results drain.
    localparam int RSP_DEPTH = 8;
    localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

endpackage

>>> design/xs1024_if.sv
// Valid/ready channel interfaces for the xorshift1024* generator.
// Depends on xs1024_pkg for field widths.
interface xs1024_req_if import xs1024_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]    word_index;
    logic [WORD_W-1:0]   word_value;

    modport source (output valid, output action, output word_index, output word_value,
                    input ready);
    modport sink   (input valid, input action, input word_index, input word_value,
                    output ready);
endinterface

interface xs1024_rsp_if import xs1024_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

>>> design/xs1024_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module xs1024_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/xorshift1024_star_generator.sv
// xorshift1024* generator: 16 x 64-bit state in two mirrored RAMs, 4-bit position.
// Throughput: one request per cycle, set by the single RAM write port at the mix stage;
// ready drops while generate credits equal RSP_DEPTH. A generate request passes
// RAM read, mix and write-back, partial products, final sum into the result queue.
// Reset: position and all control clear at once; 16 valid bits make every word read zero.
// Depends on xs1024_pkg, xs1024_req_if / xs1024_rsp_if and xs1024_ram.
module xorshift1024_star_generator import xs1024_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    xs1024_req_if.sink        request,
    xs1024_rsp_if.source      result
);

    localparam logic [31:0] MULT_LO = MIX_MULT[31:0];
    localparam logic [31:0] MULT_HI = MIX_MULT[63:32];

    logic                  req_fire;
    logic                  rsp_fire;
    logic [IDX_W-1:0]      position_reg;
    logic [IDX_W-1:0]      position_next;
    logic [IDX_W-1:0]      position_inc;

    // Stage 1: RAM data available, mix and write back
    logic                  s1_gen_reg;
    logic                  s1_load_reg;
    logic [IDX_W-1:0]      s1_addr_cur_reg;
    logic [IDX_W-1:0]      s1_addr_nxt_reg;
    logic [WORD_W-1:0]     s1_value_reg;

    // Last write, for forwarding into stage 1
    logic                  fwd_valid_reg;
    logic [IDX_W-1:0]      fwd_addr_reg;
    logic [WORD_W-1:0]     fwd_data_reg;

    logic [STATE_WORDS-1:0] word_valid_reg;

    logic [WORD_W-1:0]     ram_cur;
    logic [WORD_W-1:0]     ram_nxt;
    logic [WORD_W-1:0]     cur_word;
    logic [WORD_W-1:0]     nxt_word;
    logic [WORD_W-1:0]     nxt_shifted;
    logic [WORD_W-1:0]     mixed;
    logic                  wr_en;
    logic [WORD_W-1:0]     wr_data;

    // Stage 2: mixed word
    logic                  s2_valid_reg;
    logic [WORD_W-1:0]     s2_mixed_reg;

    // Stage 3: partial products
    logic                  s3_valid_reg;
    logic [WORD_W-1:0]     s3_prod_ll_reg;
    logic [31:0]           s3_prod_hl_reg;
    logic [31:0]           s3_prod_lh_reg;
    logic [WORD_W-1:0]     prod_ll;
    logic [31:0]           prod_hl;
    logic [31:0]           prod_lh;
    logic [WORD_W-1:0]     scrambled;

    // Result queue with credit count of generate requests in flight
    logic [WORD_W-1:0]     rsp_mem_reg [RSP_DEPTH];
    logic [RSP_PTR_W:0]    rsp_wr_ptr_reg;
    logic [RSP_PTR_W:0]    rsp_rd_ptr_reg;
    logic [RSP_PTR_W:0]    credit_reg;
    logic [RSP_PTR_W:0]    credit_next;
    logic                  req_gen;

    assign req_fire      = request.valid && request.ready;
    assign rsp_fire      = result.valid && result.ready;
    assign request.ready = (credit_reg != (RSP_PTR_W+1)'(RSP_DEPTH));
    assign req_gen       = req_fire && (request.action == ACT_GENERATE);
    assign position_inc  = position_reg + 1'b1;

    always_comb
    begin
        position_next = position_reg;
        if (req_fire)
        begin
            case (request.action)
                ACT_GENERATE:     position_next = position_inc;
                ACT_SET_POSITION: position_next = request.word_index;
                default:          position_next = position_reg;
            endcase
        end
    end

    xs1024_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_ram_cur (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_nxt_reg),
        .wr_data (wr_data),
        .rd_addr (position_reg),
        .rd_data (ram_cur)
    );

    xs1024_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_ram_nxt (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_nxt_reg),
        .wr_data (wr_data),
        .rd_addr (position_inc),
        .rd_data (ram_nxt)
    );

    // Take the word written on the edge of the read; never-written words read zero
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_cur_reg))
            cur_word = fwd_data_reg;
        else if (word_valid_reg[s1_addr_cur_reg])
            cur_word = ram_cur;
        else
            cur_word = '0;

        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_nxt_reg))
            nxt_word = fwd_data_reg;
        else if (word_valid_reg[s1_addr_nxt_reg])
            nxt_word = ram_nxt;
        else
            nxt_word = '0;
    end

    assign nxt_shifted = nxt_word ^ (nxt_word << SHIFT_A);
    assign mixed       = nxt_shifted ^ cur_word ^ (nxt_shifted >> SHIFT_B) ^ (cur_word >> SHIFT_C);
    assign wr_en       = s1_gen_reg || s1_load_reg;
    assign wr_data     = s1_gen_reg ? mixed : s1_value_reg;

    // Low 64 bits of the product: the high-by-high term drops out
    assign prod_ll   = {32'd0, s2_mixed_reg[31:0]} * {32'd0, MULT_LO};
    assign prod_hl   = 32'(s2_mixed_reg[63:32] * MULT_LO);
    assign prod_lh   = 32'(s2_mixed_reg[31:0] * MULT_HI);
    assign scrambled = s3_prod_ll_reg + {s3_prod_hl_reg + s3_prod_lh_reg, 32'd0};

    always_comb
    begin
        credit_next = credit_reg;
        if (req_gen && !rsp_fire)
            credit_next = credit_reg + 1'b1;
        else if (!req_gen && rsp_fire)
            credit_next = credit_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            s1_gen_reg     <= 1'b0;
            s1_load_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            word_valid_reg <= '0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            rsp_wr_ptr_reg <= '0;
            rsp_rd_ptr_reg <= '0;
            credit_reg     <= '0;
        end
        else
        begin
            position_reg  <= position_next;
            s1_gen_reg    <= req_gen;
            s1_load_reg   <= req_fire && (request.action == ACT_LOAD_WORD);
            fwd_valid_reg <= wr_en;
            if (wr_en)
            begin
                word_valid_reg[s1_addr_nxt_reg] <= 1'b1;
            end
            s2_valid_reg <= s1_gen_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s3_valid_reg)
            begin
                rsp_wr_ptr_reg <= rsp_wr_ptr_reg + 1'b1;
            end
            if (rsp_fire)
            begin
                rsp_rd_ptr_reg <= rsp_rd_ptr_reg + 1'b1;
            end
            credit_reg <= credit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (request.action == ACT_LOAD_WORD)
        begin
            s1_addr_cur_reg <= request.word_index;
            s1_addr_nxt_reg <= request.word_index;
        end
        else
        begin
            s1_addr_cur_reg <= position_reg;
            s1_addr_nxt_reg <= position_inc;
        end
        s1_value_reg   <= request.word_value;
        fwd_addr_reg   <= s1_addr_nxt_reg;
        fwd_data_reg   <= wr_data;
        s2_mixed_reg   <= mixed;
        s3_prod_ll_reg <= prod_ll;
        s3_prod_hl_reg <= prod_hl;
        s3_prod_lh_reg <= prod_lh;
        if (s3_valid_reg)
        begin
            rsp_mem_reg[rsp_wr_ptr_reg[RSP_PTR_W-1:0]] <= scrambled;
        end
    end

    assign result.valid        = (rsp_wr_ptr_reg != rsp_rd_ptr_reg);
    assign result.random_value = rsp_mem_reg[rsp_rd_ptr_reg[RSP_PTR_W-1:0]];

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= (RSP_PTR_W+1)'(RSP_DEPTH))
        else $error("generate credit count above queue depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_wr_ptr_reg - rsp_rd_ptr_reg) <= credit_reg)
        else $error("result queue holds more than the requests in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_gen |=> ##2 s3_valid_reg)
        else $error("generate request lost in pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> word_valid_reg[fwd_addr_reg] && fwd_valid_reg)
        else $error("state write not marked valid");
`endif

endmodule

>>> tb/sv/tb_xorshift1024_star_generator.sv
// Testbench for xorshift1024_star_generator: directed and random request streams,
// random stalls on both channels, results checked against an in-bench generator model.
// Depends on xs1024_pkg, xs1024_req_if / xs1024_rsp_if and the generator RTL.
`timescale 1ns / 100ps

class random_value_checker;
    logic [xs1024_pkg::WORD_W-1:0] gen_words [xs1024_pkg::STATE_WORDS];
    logic [xs1024_pkg::IDX_W-1:0]  gen_position;
    logic [xs1024_pkg::WORD_W-1:0] expected_values [$];
    int                            mismatch_count;
    int                            values_checked;

    function new();
        foreach (gen_words[i])
            gen_words[i] = '0;
        gen_position   = '0;
        mismatch_count = 0;
        values_checked = 0;
    endfunction

    task report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // Advance the generator by one step and return the scrambled value.
    function logic [xs1024_pkg::WORD_W-1:0] next_random_value();
        logic [xs1024_pkg::WORD_W-1:0] cur;
        logic [xs1024_pkg::WORD_W-1:0] nxt;
        logic [xs1024_pkg::WORD_W-1:0] mixed;
        cur          = gen_words[gen_position];
        gen_position = gen_position + 1'b1;
        nxt          = gen_words[gen_position];
        nxt          = nxt ^ (nxt << xs1024_pkg::SHIFT_A);
        mixed        = nxt ^ cur ^ (nxt >> xs1024_pkg::SHIFT_B) ^ (cur >> xs1024_pkg::SHIFT_C);
        gen_words[gen_position] = mixed;
        return mixed * xs1024_pkg::MIX_MULT;
    endfunction

    function void note_request(input logic [xs1024_pkg::ACTION_W-1:0] action,
                               input logic [xs1024_pkg::IDX_W-1:0]    word_index,
                               input logic [xs1024_pkg::WORD_W-1:0]   word_value);
        case (action)
            xs1024_pkg::ACT_GENERATE:     expected_values.push_back(next_random_value());
            xs1024_pkg::ACT_LOAD_WORD:    gen_words[word_index] = word_value;
            xs1024_pkg::ACT_SET_POSITION: gen_position = word_index;
            default: ;  // unused code: no effect
        endcase
    endfunction

    task check_result(input logic [xs1024_pkg::WORD_W-1:0] random_value);
        logic [xs1024_pkg::WORD_W-1:0] want;
        values_checked++;
        if (expected_values.size() == 0)
            report_mismatch($sformatf("unexpected random_value %h", random_value));
        else begin
            want = expected_values.pop_front();
            if (random_value !== want)
                report_mismatch($sformatf("random_value got %h expected %h",
                                          random_value, want));
        end
    endtask

    function int pending_count();
        return expected_values.size();
    endfunction
endclass

module tb_xorshift1024_star_generator;
    import xs1024_pkg::*;

    localparam int STALL_LIMIT    = 1000;
    localparam int HOLD_OFF_LEN   = 80;
    localparam int HOLD_OFF_AFTER = 150;
    localparam int RANDOM_ITEMS   = 600;

    logic clk;
    logic rst_n;
    bit   no_idle_stretch;
    int   quiet_cycles;

    random_value_checker value_checker;

    xs1024_req_if request ();
    xs1024_rsp_if result ();

    xorshift1024_star_generator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Drive one request from a falling edge; return at the falling edge after acceptance.
    task send_request(input logic [ACTION_W-1:0] action,
                      input logic [IDX_W-1:0]    word_index,
                      input logic [WORD_W-1:0]   word_value);
        while (!no_idle_stretch && $urandom_range(99) < 19)
        begin
            request.valid <= 1'b0;
            @(negedge clk);
        end
        request.valid      <= 1'b1;
        request.action     <= action;
        request.word_index <= word_index;
        request.word_value <= word_value;
        do
            @(posedge clk);
        while (!request.ready);
        value_checker.note_request(action, word_index, word_value);
        @(negedge clk);
    endtask

    function logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(9))
            0: w = '1;
            1: w = {1'b1, {(WORD_W-1){1'b0}}};
            2: w = 64'd1;
            default: ;
        endcase
        return w;
    endfunction

    task send_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            send_request(ACT_GENERATE, IDX_W'($urandom), random_word());
        else if (pick < 85)
            send_request(ACT_LOAD_WORD, IDX_W'($urandom), random_word());
        else if (pick < 95)
            send_request(ACT_SET_POSITION, IDX_W'($urandom), random_word());
        else
            send_request(ACTION_W'(3), IDX_W'($urandom), random_word());
    endtask

    // Receiver: random stalls, one long hold-off so the block backs up into its input.
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && value_checker.values_checked >= HOLD_OFF_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else if (!no_idle_stretch && $urandom_range(99) < 19)
                result.ready <= 1'b0;
            else
                result.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            value_checker.check_result(result.random_value);
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (request.valid && request.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        value_checker      = new();
        no_idle_stretch    = 1'b0;
        rst_n              = 1'b0;
        request.valid      <= 1'b0;
        request.action     <= ACT_GENERATE;
        request.word_index <= '0;
        request.word_value <= '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Zero seed: all-zero state gives zero and stays zero.
        send_request(ACT_GENERATE, '0, '0);
        send_request(ACTION_W'(3), '1, '1);      // unused code, ignored
        send_request(ACT_GENERATE, '1, '1);
        // Seed with extreme words.
        send_request(ACT_LOAD_WORD, 4'd0, '1);
        send_request(ACT_LOAD_WORD, 4'd15, 64'h8000_0000_0000_0001);
        send_request(ACT_LOAD_WORD, 4'd1, 64'd1);
        send_request(ACT_LOAD_WORD, 4'd5, {$urandom, $urandom});
        send_request(ACT_LOAD_WORD, 4'd10, '0);
        send_request(ACT_LOAD_WORD, 4'd7, 64'h5555_5555_5555_5555);
        send_request(ACT_GENERATE, '0, '0);
        send_request(ACT_GENERATE, '0, '0);
        // Position wrap from 15 to 0.
        send_request(ACT_SET_POSITION, 4'd15, '1);
        send_request(ACT_GENERATE, '0, '0);
        send_request(ACT_GENERATE, '0, '0);
        send_request(ACTION_W'(3), 4'd5, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(ACT_SET_POSITION, 4'd0, '0);
        send_request(ACT_GENERATE, '1, '1);
        send_request(ACT_SET_POSITION, 4'd14, '0);
        send_request(ACT_GENERATE, '0, '0);
        send_request(ACT_GENERATE, '0, '0);
        send_request(ACT_GENERATE, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle_stretch = (n >= 250 && n < 400);
            if (n == 450)
            begin
                // Pause until the result channel drains.
                request.valid <= 1'b0;
                while (value_checker.pending_count() != 0)
                    @(negedge clk);
            end
            send_random_item();
        end
        no_idle_stretch = 1'b0;
        request.valid <= 1'b0;

        while (value_checker.pending_count() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (value_checker.pending_count() != 0)
            value_checker.report_mismatch($sformatf("%0d results never arrived",
                                                    value_checker.pending_count()));
        if (value_checker.mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
